// ===== rtl/ckse_pkg.sv =====
// Shared types and constants for the colour key span extractor.
// Holds the result record, register map codes and pixel format codes.
// No dependencies.
package ckse_pkg;

    // Fixed field widths of the result record
    localparam int EDGE_W  = 13;
    localparam int COUNT_W = 24;

    // Register map (index = byte address / 4)
    localparam int          APB_ADDR_W = 5;
    localparam logic [2:0]  REG_KEY    = 3'd0;
    localparam logic [2:0]  REG_FORMAT = 3'd1;
    localparam logic [2:0]  REG_INVERT = 3'd2;
    localparam logic [2:0]  REG_WIDTH  = 3'd3;
    localparam logic [2:0]  REG_HEIGHT = 3'd4;

    // Pixel format codes
    localparam logic [1:0] FMT_RGB555 = 2'd0;
    localparam logic [1:0] FMT_BGR24  = 2'd1;
    localparam logic [1:0] FMT_BGRX32 = 2'd2;

    // Result kinds
    localparam logic KIND_SPAN    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Register reset values
    localparam logic [23:0]       KEY_RST    = 24'h000000;
    localparam logic [1:0]        FORMAT_RST = FMT_BGRX32;
    localparam logic              INVERT_RST = 1'b0;
    localparam logic [EDGE_W-1:0] WIDTH_RST  = 13'd4096;
    localparam logic [EDGE_W-1:0] HEIGHT_RST = 13'd4096;

    // Output queue geometry
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic               item_kind;
        logic [EDGE_W-1:0]  left_edge;
        logic [EDGE_W-1:0]  top_edge;
        logic [EDGE_W-1:0]  right_edge;
        logic [EDGE_W-1:0]  bottom_edge;
        logic [COUNT_W-1:0] span_total;
        logic               last;
    } result_t;

    // Key colour reduced to 5 bits per channel, bit 15 clear
    function automatic logic [15:0] key_to_555(input logic [23:0] key);
        return {1'b0, key[23:19], key[15:11], key[7:3]};
    endfunction

endpackage

// ===== rtl/ckse_key_match.sv =====
// Pixel against key colour compare for the span extractor.
// Depends on ckse_pkg for format codes and the 555 key reduction.
module ckse_key_match (
    input  logic [31:0] pixel_word,
    input  logic [23:0] key_color,
    input  logic [1:0]  pixel_format,
    output logic        is_key
);
    import ckse_pkg::*;

    logic [15:0] key_555;

    assign key_555 = key_to_555(key_color);

    // 555 compares all 16 bits (bit 15 set never matches); others compare R, G, B
    always_comb begin
        unique case (pixel_format)
            FMT_RGB555: is_key = (pixel_word[15:0] == key_555);
            FMT_BGR24:  is_key = (pixel_word[23:0] == key_color);
            FMT_BGRX32: is_key = (pixel_word[23:0] == key_color);
            default:    is_key = (pixel_word[23:0] == key_color);
        endcase
    end

endmodule

// ===== rtl/ckse_out_fifo.sv =====
// Result queue for the span extractor: takes up to two results a cycle,
// hands out one a cycle on a valid/ready channel.
// Depends on ckse_pkg for result_t and the queue geometry.
module ckse_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  ckse_pkg::result_t push_data0,
    input  ckse_pkg::result_t push_data1,
    output logic              has_room,
    output logic              m_valid,
    input  logic              m_ready,
    output ckse_pkg::result_t m_data
);
    import ckse_pkg::*;

    result_t                mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;

    assign m_valid  = (count_reg != '0);
    assign m_data   = mem_reg[rd_ptr_reg];
    assign pop      = m_valid & m_ready;
    // room for a worst-case pair whatever the consumer does this cycle
    assign has_room = (count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= push_data1;
        end
    end

    // pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        count_next  = count_reg + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/color_key_span_extract.sv =====
// Colour key span extractor, top level. A result enters the result queue on its
// pixel transaction and is offered on m_ from there. Throughput: one pixel per
// cycle while s_ready is high; a pixel that closes a span and ends the frame
// yields two results into the four-entry queue (s_ready low while it holds > 2).
// Reset (aresetn, synchronous, active low) restores registers and starts a new
// frame. Depends on ckse_pkg, ckse_key_match and ckse_out_fifo.
module color_key_span_extract #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ckse_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // pixel input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [31:0]                        s_pixel_word,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_item_kind,
    output logic [ckse_pkg::EDGE_W-1:0]        m_left_edge,
    output logic [ckse_pkg::EDGE_W-1:0]        m_top_edge,
    output logic [ckse_pkg::EDGE_W-1:0]        m_right_edge,
    output logic [ckse_pkg::EDGE_W-1:0]        m_bottom_edge,
    output logic [ckse_pkg::COUNT_W-1:0]       m_span_total,
    output logic                               m_last
);
    import ckse_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (CW > EDGE_W) ? CW : EDGE_W;
    localparam int HCMP = (RW > EDGE_W) ? RW : EDGE_W;

    // configuration registers
    logic [23:0]       key_reg;
    logic [1:0]        format_reg;
    logic              invert_reg;
    logic [EDGE_W-1:0] width_reg;
    logic [EDGE_W-1:0] height_reg;

    // frame state
    logic [CW-1:0]      column_reg, column_next;
    logic [RW-1:0]      row_reg, row_next;
    logic               run_open_reg, run_open_next;
    logic [CW-1:0]      run_start_reg, run_start_next;
    logic [CW-1:0]      bound_left_reg, bound_left_next;
    logic [RW-1:0]      bound_top_reg, bound_top_next;
    logic [CW-1:0]      bound_right_reg, bound_right_next;
    logic [RW-1:0]      bound_bottom_reg, bound_bottom_next;
    logic [COUNT_W-1:0] span_count_reg, span_count_next;

    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic               accept;
    logic               is_key;
    logic               in_span;
    logic [WCMP-1:0]    width_ext;
    logic [HCMP-1:0]    height_ext;
    logic [CW-1:0]      width_eff;
    logic [RW-1:0]      height_eff;
    logic [CW-1:0]      col_inc;
    logic [RW-1:0]      row_inc;
    logic               row_end;
    logic               frame_end;
    logic               span_emit;
    logic [CW-1:0]      span_start;
    logic [CW-1:0]      span_end;
    logic [1:0]         push_cnt;
    logic               has_room;
    result_t            span_res;
    result_t            summary_res;
    result_t            push_data0;
    result_t            push_data1;
    result_t            out_res;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= KEY_RST;
            format_reg <= FORMAT_RST;
            invert_reg <= INVERT_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_write) begin
            if (cfg_index == REG_KEY)    key_reg    <= pwdata[23:0];
            if (cfg_index == REG_FORMAT) format_reg <= pwdata[1:0];
            if (cfg_index == REG_INVERT) invert_reg <= pwdata[0];
            if (cfg_index == REG_WIDTH)  width_reg  <= pwdata[EDGE_W-1:0];
            if (cfg_index == REG_HEIGHT) height_reg <= pwdata[EDGE_W-1:0];
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_index)
            REG_KEY:    prdata = {8'd0, key_reg};
            REG_FORMAT: prdata = {30'd0, format_reg};
            REG_INVERT: prdata = {31'd0, invert_reg};
            REG_WIDTH:  prdata = {{(32 - EDGE_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32 - EDGE_W){1'b0}}, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- effective frame size ----------------
    // zero acts as one, anything above the maximum is clamped
    assign width_ext  = WCMP'(width_reg);
    assign height_ext = HCMP'(height_reg);

    always_comb begin
        if (width_ext == '0)
            width_eff = CW'(1);
        else if (width_ext > WCMP'(MAX_WIDTH))
            width_eff = CW'(MAX_WIDTH);
        else
            width_eff = CW'(width_ext);

        if (height_ext == '0)
            height_eff = RW'(1);
        else if (height_ext > HCMP'(MAX_HEIGHT))
            height_eff = RW'(MAX_HEIGHT);
        else
            height_eff = RW'(height_ext);
    end

    // ---------------- pixel classification ----------------
    ckse_key_match u_key_match (
        .pixel_word   (s_pixel_word),
        .key_color    (key_reg),
        .pixel_format (format_reg),
        .is_key       (is_key)
    );

    assign in_span = ~(is_key ^ invert_reg);
    assign accept = s_valid & s_ready;
    assign s_ready = has_room;

    // ---------------- span and frame tracking ----------------
    assign col_inc   = column_reg + CW'(1);
    assign row_inc   = row_reg + RW'(1);
    assign row_end   = (col_inc >= width_eff);
    assign frame_end = row_end & ~(row_inc < height_eff);

    // an inside pixel closes its run only at row end; an outside one closes an open run
    assign span_emit  = in_span ? row_end : run_open_reg;
    assign span_start = run_open_reg ? run_start_reg : column_reg;
    assign span_end   = in_span ? col_inc : column_reg;

    always_comb begin
        bound_left_next   = bound_left_reg;
        bound_top_next    = bound_top_reg;
        bound_right_next  = bound_right_reg;
        bound_bottom_next = bound_bottom_reg;
        span_count_next   = span_count_reg;
        if (span_emit) begin
            if (span_start < bound_left_reg)  bound_left_next   = span_start;
            if (row_reg < bound_top_reg)      bound_top_next    = row_reg;
            if (span_end > bound_right_reg)   bound_right_next  = span_end;
            if (row_inc > bound_bottom_reg)   bound_bottom_next = row_inc;
            span_count_next = span_count_reg + COUNT_W'(1);
        end

        run_open_next  = in_span & ~row_end;
        run_start_next = (in_span & ~run_open_reg) ? column_reg : run_start_reg;
        column_next    = row_end ? '0 : col_inc;
        row_next       = row_end ? row_inc : row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg       <= '0;
            row_reg          <= '0;
            run_open_reg     <= 1'b0;
            run_start_reg    <= '0;
            bound_left_reg   <= CW'(MAX_WIDTH);
            bound_top_reg    <= RW'(MAX_HEIGHT);
            bound_right_reg  <= '0;
            bound_bottom_reg <= '0;
            span_count_reg   <= '0;
        end else if (accept) begin
            if (frame_end) begin
                // start the next frame from the sentinels
                column_reg       <= '0;
                row_reg          <= '0;
                run_open_reg     <= 1'b0;
                run_start_reg    <= '0;
                bound_left_reg   <= CW'(MAX_WIDTH);
                bound_top_reg    <= RW'(MAX_HEIGHT);
                bound_right_reg  <= '0;
                bound_bottom_reg <= '0;
                span_count_reg   <= '0;
            end else begin
                column_reg       <= column_next;
                row_reg          <= row_next;
                run_open_reg     <= run_open_next;
                run_start_reg    <= run_start_next;
                bound_left_reg   <= bound_left_next;
                bound_top_reg    <= bound_top_next;
                bound_right_reg  <= bound_right_next;
                bound_bottom_reg <= bound_bottom_next;
                span_count_reg   <= span_count_next;
            end
        end
    end

    // ---------------- result records ----------------
    always_comb begin
        span_res.item_kind   = KIND_SPAN;
        span_res.left_edge   = EDGE_W'(span_start);
        span_res.top_edge    = EDGE_W'(row_reg);
        span_res.right_edge  = EDGE_W'(span_end);
        span_res.bottom_edge = EDGE_W'(row_inc);
        span_res.span_total  = span_count_next;
        span_res.last        = ~frame_end;

        summary_res.item_kind   = KIND_SUMMARY;
        summary_res.left_edge   = EDGE_W'(bound_left_next);
        summary_res.top_edge    = EDGE_W'(bound_top_next);
        summary_res.right_edge  = EDGE_W'(bound_right_next);
        summary_res.bottom_edge = EDGE_W'(bound_bottom_next);
        summary_res.span_total  = span_count_next;
        summary_res.last        = 1'b1;

        push_data0 = span_emit ? span_res : summary_res;
        push_data1 = summary_res;

        if (accept)
            push_cnt = 2'(span_emit) + 2'(frame_end);
        else
            push_cnt = 2'd0;
    end

    ckse_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .has_room   (has_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (out_res)
    );

    assign m_item_kind   = out_res.item_kind;
    assign m_left_edge   = out_res.left_edge;
    assign m_top_edge    = out_res.top_edge;
    assign m_right_edge  = out_res.right_edge;
    assign m_bottom_edge = out_res.bottom_edge;
    assign m_span_total  = out_res.span_total;
    assign m_last        = out_res.last;

endmodule
